@@ rtl/set_assoc_cache_tag_lookup_macros.svh @@
// Assertion macros for the cache tag lookup block.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`ifndef ASSERT_OFF
`define SACL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define SACL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sacl_pkg.sv @@
package sacl_pkg;

  // Default geometry of the cache.
  localparam int WAYS_DEF        = 4;
  localparam int INDEX_BITS_DEF  = 6;
  localparam int OFFSET_BITS_DEF = 4;
  localparam int ADDR_BITS_DEF   = 32;

  // Fixed field widths of the stream items.
  localparam int ADDRESS_W   = 32;
  localparam int WAY_FIELD_W = 2;
  localparam int COUNT_W     = 32;
  localparam int STAMP_W     = 64;
  localparam int OUT_TDATA_W = 72;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    POLICY_LRU = 1'b0,
    POLICY_RR  = 1'b1
  } sacl_policy_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } sacl_state_e;

  typedef struct packed {
    logic clearing;
    logic commit;
  } back_status_t;

  function automatic int at_least_one(input int value);
    return (value < 1) ? 1 : value;
  endfunction

  function automatic int eff_addr_w(input int addr_bits);
    return (addr_bits < ADDRESS_W) ? addr_bits : ADDRESS_W;
  endfunction

endpackage

@@ rtl/sacl_queue.sv @@
module sacl_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int DEPTH = sacl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = sacl_pkg::at_least_one($clog2(DEPTH));
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/sacl_front.sv @@
module sacl_front #(
  parameter int INDEX_BITS  = sacl_pkg::INDEX_BITS_DEF,
  parameter int OFFSET_BITS = sacl_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = sacl_pkg::ADDR_BITS_DEF
) (
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sacl_pkg::ADDRESS_W-1:0] s_axis_tdata_i,
  input  logic                           clearing_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output logic [sacl_pkg::at_least_one(
      sacl_pkg::eff_addr_w(ADDR_BITS) - OFFSET_BITS - INDEX_BITS)-1:0] push_tag_o,
  output logic [sacl_pkg::at_least_one(INDEX_BITS)-1:0] push_set_o
);

  localparam int AW    = sacl_pkg::eff_addr_w(ADDR_BITS);
  localparam int TAG_W = sacl_pkg::at_least_one(AW - OFFSET_BITS - INDEX_BITS);
  localparam int SET_W = sacl_pkg::at_least_one(INDEX_BITS);

  logic [AW-1:0] addr;

  // Address bits above the configured width play no part in the lookup.
  assign addr = s_axis_tdata_i[AW-1:0];

  assign push_tag_o = TAG_W'(addr >> (OFFSET_BITS + INDEX_BITS));
  assign push_set_o = (INDEX_BITS == 0) ? '0 : SET_W'(addr >> OFFSET_BITS);

  // No item enters while the back is still clearing the set memory.
  assign s_axis_tready_o = push_ready_i && !clearing_i;
  assign push_valid_o    = s_axis_tvalid_i && !clearing_i;

endmodule

@@ rtl/sacl_back.sv @@
module sacl_back #(
  parameter int WAYS        = sacl_pkg::WAYS_DEF,
  parameter int INDEX_BITS  = sacl_pkg::INDEX_BITS_DEF,
  parameter int OFFSET_BITS = sacl_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = sacl_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sacl_pkg::sacl_policy_e            policy_i,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic [sacl_pkg::at_least_one(
      sacl_pkg::eff_addr_w(ADDR_BITS) - OFFSET_BITS - INDEX_BITS)-1:0] req_tag_i,
  input  logic [sacl_pkg::at_least_one(INDEX_BITS)-1:0] req_set_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_hit_o,
  output logic [sacl_pkg::WAY_FIELD_W-1:0]  out_way_o,
  output logic [sacl_pkg::COUNT_W-1:0]      out_hits_o,
  output logic [sacl_pkg::COUNT_W-1:0]      out_misses_o,
  output sacl_pkg::back_status_t            status_o
);

  localparam int AW      = sacl_pkg::eff_addr_w(ADDR_BITS);
  localparam int TAG_W   = sacl_pkg::at_least_one(AW - OFFSET_BITS - INDEX_BITS);
  localparam int SET_W   = sacl_pkg::at_least_one(INDEX_BITS);
  localparam int SETS    = 1 << INDEX_BITS;
  localparam int WAY_W   = sacl_pkg::at_least_one($clog2(WAYS));
  localparam int P       = 1 << WAY_W;
  localparam int STAMP_W = sacl_pkg::STAMP_W;
  localparam int WF      = sacl_pkg::WAY_FIELD_W;

  // One row per set holds every way of that set.
  logic [WAYS-1:0][TAG_W-1:0]   tag_mem   [SETS];
  logic [WAYS-1:0][STAMP_W-1:0] stamp_mem [SETS];
  logic [WAYS-1:0]              valid_mem [SETS];
  logic [WAY_W-1:0]             rr_mem    [SETS];

  logic [WAYS-1:0][TAG_W-1:0]   rd_tags_q;
  logic [WAYS-1:0][STAMP_W-1:0] rd_stamps_q;
  logic [WAYS-1:0]              rd_valid_q;
  logic [WAY_W-1:0]             rd_rr_q;

  logic                         wr_en;
  logic [SET_W-1:0]             wr_addr;
  logic [WAYS-1:0][TAG_W-1:0]   wr_tags;
  logic [WAYS-1:0][STAMP_W-1:0] wr_stamps;
  logic [WAYS-1:0]              wr_valid;
  logic [WAY_W-1:0]             wr_rr;

  sacl_pkg::sacl_state_e state_q, state_d;
  logic [SET_W-1:0]             clr_q;
  logic [STAMP_W-1:0]           access_stamp_q;
  logic [sacl_pkg::COUNT_W-1:0] hits_q, misses_q;
  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [WF-1:0]                out_way_q;
  logic [TAG_W-1:0]             tag_q;
  logic [SET_W-1:0]             set_q;

  logic                         rd_en;
  logic                         commit;
  logic [WAYS-1:0]              hit_vec;
  logic                         hit;
  logic [WAY_W-1:0]             hit_way;
  logic [WAY_W-1:0]             lru_way;
  logic [WAY_W-1:0]             rr_next;
  logic [WAY_W-1:0]             victim;
  logic [WAY_W-1:0]             sel_way;
  logic [STAMP_W-1:0]           tv [P];
  logic [WAY_W-1:0]             ti [P];

  // Tag match against every valid way; the lowest matching way wins.
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = rd_valid_q[w] && (rd_tags_q[w] == tag_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  assign hit = |hit_vec;

  // Tournament over the stamps. An invalid way counts as stamp zero, and the
  // left side wins a tie so equal stamps go to the lowest way. Padding slots
  // carry the largest stamp and lose to every real way.
  always_comb begin
    for (int i = 0; i < P; i++) begin
      ti[i] = WAY_W'(i);
      if (i < WAYS) begin
        tv[i] = rd_valid_q[i] ? rd_stamps_q[i] : '0;
      end else begin
        tv[i] = '1;
      end
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int i = 0; i < P; i += (2 << l)) begin
        if (tv[i + (1 << l)] < tv[i]) begin
          tv[i] = tv[i + (1 << l)];
          ti[i] = ti[i + (1 << l)];
        end
      end
    end
    lru_way = ti[0];
  end

  assign rr_next = (rd_rr_q == WAY_W'(WAYS - 1)) ? '0 : rd_rr_q + 1'b1;
  assign victim  = (policy_i == sacl_pkg::POLICY_RR) ? rr_next : lru_way;
  assign sel_way = hit ? hit_way : victim;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    rd_en       = 1'b0;
    commit      = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = set_q;
    wr_tags     = rd_tags_q;
    wr_stamps   = rd_stamps_q;
    wr_valid    = rd_valid_q;
    wr_rr       = rd_rr_q;
    case (state_q)
      sacl_pkg::ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_q;
        wr_tags   = '0;
        wr_stamps = '0;
        wr_valid  = '0;
        wr_rr     = '0;
        if (clr_q == SET_W'(SETS - 1)) begin
          state_d = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          rd_en   = 1'b1;
          state_d = sacl_pkg::ST_EVAL;
        end
      end
      sacl_pkg::ST_EVAL: begin
        // The result register must be free before the set row is updated.
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          wr_en   = 1'b1;
          state_d = sacl_pkg::ST_IDLE;
          if (hit) begin
            if (policy_i == sacl_pkg::POLICY_LRU) begin
              wr_stamps[hit_way] = access_stamp_q;
            end
          end else begin
            wr_tags[victim]   = tag_q;
            wr_valid[victim]  = 1'b1;
            wr_stamps[victim] = access_stamp_q;
            if (policy_i == sacl_pkg::POLICY_RR) begin
              wr_rr = victim;
            end
          end
        end
      end
      default: begin
        state_d = sacl_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= sacl_pkg::ST_CLEAR;
      clr_q          <= '0;
      access_stamp_q <= '0;
      hits_q         <= '0;
      misses_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == sacl_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (rd_en) begin
        access_stamp_q <= access_stamp_q + 1'b1;
      end
      if (commit) begin
        if (hit) begin
          hits_q <= hits_q + 1'b1;
        end else begin
          misses_q <= misses_q + 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      tag_q <= req_tag_i;
      set_q <= req_set_i;
    end
    if (commit) begin
      out_hit_q <= hit;
      out_way_q <= WF'(sel_way);
    end
  end

  // Set row memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_addr]   <= wr_tags;
      stamp_mem[wr_addr] <= wr_stamps;
      valid_mem[wr_addr] <= wr_valid;
      rr_mem[wr_addr]    <= wr_rr;
    end
    if (rd_en) begin
      rd_tags_q   <= tag_mem[req_set_i];
      rd_stamps_q <= stamp_mem[req_set_i];
      rd_valid_q  <= valid_mem[req_set_i];
      rd_rr_q     <= rr_mem[req_set_i];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_hit_o       = out_hit_q;
  assign out_way_o       = out_way_q;
  assign out_hits_o      = hits_q;
  assign out_misses_o    = misses_q;
  assign status_o.clearing = (state_q == sacl_pkg::ST_CLEAR);
  assign status_o.commit   = commit;

endmodule

@@ rtl/set_assoc_cache_tag_lookup.sv @@
// Set-associative cache tag lookup with LRU or round-robin replacement.
// Each item on the slave stream is one byte address. The block splits it into
// offset, set index and tag, looks the tag up in the indexed set, updates that
// set, and returns one result item per address on the master stream: the hit
// flag in tuser, and the way plus the running hit and miss counts in tdata.
// The configuration channel writes the replacement policy (0 LRU, 1 round
// robin); it is always ready and is meant to be written only while idle.
// An accepted address passes the queue, the set row read and the write-back
// before its result is valid. The block works on one address at a time: the
// set row is read, then written back before the next item may read the same set.
// After reset the block clears the set memory, one set per cycle, all
// 2^INDEX_BITS sets (64 with the default geometry); s_axis_tready stays low
// during that pass. A short queue holds accepted addresses, so input is taken
// while a result waits. When the receiver stalls, the result register holds,
// the lookup of the next item waits, and the queue fills before tready drops.
`include "set_assoc_cache_tag_lookup_macros.svh"

module set_assoc_cache_tag_lookup #(
  parameter int WAYS        = sacl_pkg::WAYS_DEF,
  parameter int INDEX_BITS  = sacl_pkg::INDEX_BITS_DEF,
  parameter int OFFSET_BITS = sacl_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = sacl_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Replacement policy write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [0:0]                       cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sacl_pkg::ADDRESS_W-1:0]   s_axis_tdata,   // [31:0] address
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] way, [33:2] hit_count, [65:34] miss_count, [71:66] zero
  output logic [sacl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]                       m_axis_tuser    // [0] hit
);

  localparam int AW    = sacl_pkg::eff_addr_w(ADDR_BITS);
  localparam int TAG_W = sacl_pkg::at_least_one(AW - OFFSET_BITS - INDEX_BITS);
  localparam int SET_W = sacl_pkg::at_least_one(INDEX_BITS);
  localparam int REQ_W = TAG_W + SET_W;
  localparam int PAD_W = sacl_pkg::OUT_TDATA_W - sacl_pkg::WAY_FIELD_W
                         - 2 * sacl_pkg::COUNT_W;

  sacl_pkg::sacl_policy_e policy_q;

  logic                   push_valid, push_ready;
  logic [TAG_W-1:0]       push_tag;
  logic [SET_W-1:0]       push_set;
  logic                   q_valid, q_pop;
  logic [REQ_W-1:0]       q_data;
  logic                   out_hit;
  logic [sacl_pkg::WAY_FIELD_W-1:0] out_way;
  logic [sacl_pkg::COUNT_W-1:0]     out_hits, out_misses;
  sacl_pkg::back_status_t st;

  // The policy register takes every write; only bit 0 means anything.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= sacl_pkg::POLICY_LRU;
    end else if (cfg_valid_i) begin
      policy_q <= sacl_pkg::sacl_policy_e'(cfg_data_i[0]);
    end
  end

  sacl_front #(
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .clearing_i      (st.clearing),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_tag_o      (push_tag),
    .push_set_o      (push_set)
  );

  sacl_queue #(
    .WIDTH (REQ_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_tag, push_set}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop),
    .pop_data_o   (q_data)
  );

  sacl_back #(
    .WAYS        (WAYS),
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .policy_i     (policy_q),
    .req_valid_i  (q_valid),
    .req_ready_o  (q_pop),
    .req_tag_i    (q_data[REQ_W-1:SET_W]),
    .req_set_i    (q_data[SET_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_hit_o    (out_hit),
    .out_way_o    (out_way),
    .out_hits_o   (out_hits),
    .out_misses_o (out_misses),
    .status_o     (st)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_misses, out_hits, out_way};
  assign m_axis_tuser = out_hit;

  // Nothing can be queued while the set memory is being cleared.
  `SACL_ASSERT_IMPLIES(a_clear_queue_empty, clk_i, rst_ni, st.clearing, !q_valid)
  // A set row write-back never coincides with the read of the next item.
  `SACL_ASSERT_IMPLIES(a_no_pop_on_commit, clk_i, rst_ni, st.commit, !q_pop)
  // Every finished lookup shows up as a valid result in the next cycle.
  `SACL_ASSERT_NEXT(a_commit_gives_result, clk_i, rst_ni, st.commit, m_axis_tvalid)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

// Predicts each lookup from the accepted address stream and checks the block's results in order.
class lookup_checker;
  localparam int WAYS    = sacl_pkg::WAYS_DEF;
  localparam int SETS    = 1 << sacl_pkg::INDEX_BITS_DEF;
  localparam int OFF_W   = sacl_pkg::OFFSET_BITS_DEF;
  localparam int IDX_W   = sacl_pkg::INDEX_BITS_DEF;
  localparam int TAG_W   = sacl_pkg::ADDRESS_W - IDX_W - OFF_W;

  typedef struct packed {
    logic                              hit;
    logic [sacl_pkg::WAY_FIELD_W-1:0]  way;
    logic [sacl_pkg::COUNT_W-1:0]      hit_count;
    logic [sacl_pkg::COUNT_W-1:0]      miss_count;
  } lookup_result_t;

  bit                            line_valid [WAYS][SETS];
  bit [TAG_W-1:0]                line_tag   [WAYS][SETS];
  bit [sacl_pkg::STAMP_W-1:0]    line_stamp [WAYS][SETS];
  bit [1:0]                      rr_next    [SETS];
  bit [sacl_pkg::STAMP_W-1:0]    access_count;
  bit [sacl_pkg::COUNT_W-1:0]    hit_total;
  bit [sacl_pkg::COUNT_W-1:0]    miss_total;
  sacl_pkg::sacl_policy_e        policy;
  lookup_result_t                expected_lookups[$];
  int                            fail_count;

  function new();
    policy     = sacl_pkg::POLICY_LRU;
    fail_count = 0;
  endfunction

  function void set_policy(sacl_pkg::sacl_policy_e p);
    policy = p;
  endfunction

  function int pending();
    return expected_lookups.size();
  endfunction

  // Works out the result of one access and updates the cache state.
  function void note_address(logic [sacl_pkg::ADDRESS_W-1:0] address);
    bit [TAG_W-1:0] tag;
    int             set_idx;
    int             victim;
    bit             found;
    lookup_result_t r;
    tag          = address[sacl_pkg::ADDRESS_W-1 -: TAG_W];
    set_idx      = int'(address[OFF_W +: IDX_W]);
    access_count = access_count + 1;
    found        = 1'b0;
    victim       = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[w][set_idx] && line_tag[w][set_idx] == tag) begin
        found  = 1'b1;
        victim = w;
      end
    end
    if (found) begin
      hit_total = hit_total + 1;
      if (policy == sacl_pkg::POLICY_LRU) line_stamp[victim][set_idx] = access_count;
    end else begin
      miss_total = miss_total + 1;
      if (policy == sacl_pkg::POLICY_RR) begin
        victim           = (int'(rr_next[set_idx]) + 1) % WAYS;
        rr_next[set_idx] = victim[1:0];
      end else begin
        // Invalid ways hold stamp zero; the strict compare keeps the lowest way on a tie.
        victim = 0;
        for (int w = 1; w < WAYS; w++) begin
          if (line_stamp[w][set_idx] < line_stamp[victim][set_idx]) victim = w;
        end
      end
      line_tag[victim][set_idx]   = tag;
      line_valid[victim][set_idx] = 1'b1;
      line_stamp[victim][set_idx] = access_count;
    end
    r.hit        = found;
    r.way        = victim[1:0];
    r.hit_count  = hit_total;
    r.miss_count = miss_total;
    expected_lookups.push_back(r);
  endfunction

  function void check_lookup(lookup_result_t actual);
    lookup_result_t exp_r;
    if (expected_lookups.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: result with nothing expected: hit=%0d way=%0d hits=%0d misses=%0d",
                 actual.hit, actual.way, actual.hit_count, actual.miss_count);
      return;
    end
    exp_r = expected_lookups.pop_front();
    if (actual !== exp_r) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR: lookup mismatch: expected hit=%0d way=%0d hits=%0d misses=%0d,",
                 exp_r.hit, exp_r.way, exp_r.hit_count, exp_r.miss_count);
        $display("       got hit=%0d way=%0d hits=%0d misses=%0d",
                 actual.hit, actual.way, actual.hit_count, actual.miss_count);
      end
    end
  endfunction
endclass

module tb;

  // The watchdog ends the run after this many cycles in which no item
  // moves on any channel. The clearing pass after reset moves no item.
  localparam int STALL_LIMIT = 5000;
  // Cycles to let pass once all results are in.
  localparam int DRAIN_CYCLES = 8;
  localparam int SEGMENT_ITEMS = 134;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [0:0]                         cfg_data_i    = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [sacl_pkg::ADDRESS_W-1:0]     s_axis_tdata  = '0;   // [31:0] address
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  // [1:0] way, [33:2] hit_count, [65:34] miss_count
  logic [sacl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic [0:0]                         m_axis_tuser;   // [0] hit

  lookup_checker lookups = new();

  // Idle rates in percent for the address sender and the result receiver.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int quiet_cycles  = 0;

  // A small pool of sets and tags: six tags competing for four ways of a
  // few sets give a steady mix of hits, fills and evictions.
  logic [21:0] hot_tags [6];
  logic [5:0]  hot_sets [4];

  set_assoc_cache_tag_lookup u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // The receiver decides its ready for each cycle at the clock edge.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Monitors sample at the edge, before the nonblocking updates of that step
  // land, so they see exactly the values the block sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        lookups.set_policy(sacl_pkg::sacl_policy_e'(cfg_data_i[0]));
      if (s_axis_tvalid && s_axis_tready) lookups.note_address(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        lookups.check_lookup({m_axis_tuser[0], m_axis_tdata[1:0],
                              m_axis_tdata[33:2], m_axis_tdata[65:34]});
    end
  end

  // Watchdog: counts cycles in which no item is accepted on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL set_assoc_cache_tag_lookup");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] make_addr(logic [21:0] tag, logic [5:0] set_idx,
                                            logic [3:0] offset);
    return {tag, set_idx, offset};
  endfunction

  // Three out of four random items land in the hot pool so that the sets
  // fill up and evict; the rest are fully random addresses.
  function automatic logic [31:0] pick_address();
    if ($urandom_range(0, 3) != 0)
      return make_addr(hot_tags[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 3)],
                       4'($urandom));
    return $urandom;
  endfunction

  // Offers one address and returns at the edge where it is taken. The next
  // call in the same time step keeps tvalid high for back to back items.
  task automatic push_address(logic [31:0] address);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= address;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Lets every outstanding result drain so the policy can be rewritten.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (lookups.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_policy(sacl_pkg::sacl_policy_e p);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 6; i++) hot_tags[i] = 22'($urandom);
    for (int i = 0; i < 4; i++) hot_sets[i] = 6'($urandom);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First phase: the sender idles now and then, the receiver often.
    src_idle_pct  = 9;
    sink_idle_pct = 54;
    write_policy(sacl_pkg::POLICY_LRU);

    // Directed LRU sequence. The lowest and highest addresses come first.
    // Then four tags fill set 5 in way order, since empty ways tie at stamp
    // zero; a hit refreshes tag 1 so the next miss evicts the oldest, tag 2.
    push_address(32'h0000_0000);
    push_address(32'hFFFF_FFFF);
    push_address(make_addr(22'h000001, 6'd5, 4'h0));
    push_address(make_addr(22'h000002, 6'd5, 4'h0));
    push_address(make_addr(22'h3FFFFF, 6'd5, 4'h0));
    push_address(make_addr(22'h200000, 6'd5, 4'h0));
    push_address(make_addr(22'h000001, 6'd5, 4'hF));
    push_address(make_addr(22'h155555, 6'd5, 4'h7));
    push_address(make_addr(22'h000001, 6'd5, 4'h3));
    push_address(make_addr(22'h000002, 6'd5, 4'h0));
    wait_drained();

    // Directed round robin sequence. A fresh set fills ways 1, 2, 3, 0 and
    // then wraps to way 1; set 5 still has its pointer at zero from LRU mode.
    write_policy(sacl_pkg::POLICY_RR);
    push_address(make_addr(22'h000010, 6'd9, 4'h0));
    push_address(make_addr(22'h000011, 6'd9, 4'h1));
    push_address(make_addr(22'h000012, 6'd9, 4'h2));
    push_address(make_addr(22'h000013, 6'd9, 4'h3));
    push_address(make_addr(22'h000014, 6'd9, 4'h4));
    push_address(make_addr(22'h000011, 6'd9, 4'h5));
    push_address(make_addr(22'h000010, 6'd9, 4'h6));
    push_address(make_addr(22'h000011, 6'd9, 4'h7));
    push_address(make_addr(22'h2AAAAA, 6'd5, 4'h8));
    push_address(make_addr(22'h000002, 6'd63, 4'hF));
    push_address(32'hFFFF_FFFF);
    wait_drained();

    // Random segments: the idle pattern changes every two segments and the
    // policy alternates, so each policy runs on top of state the other left.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        src_idle_pct  = 54;
        sink_idle_pct = 9;
      end else if (seg == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_policy((seg % 2 == 0) ? sacl_pkg::POLICY_LRU : sacl_pkg::POLICY_RR);
      for (int n = 0; n < SEGMENT_ITEMS; n++) push_address(pick_address());
      wait_drained();
    end

    if (lookups.fail_count == 0) begin
      $display("PASS set_assoc_cache_tag_lookup");
    end else begin
      $display("FAIL set_assoc_cache_tag_lookup");
    end
    $finish;
  end
endmodule
